>>> src/ople_pkg.sv
// Shared types and constants of the ordered list engine.
// Used by the channel interfaces, the controller, the datapath and the checker.
package ople_pkg;

   // Field widths of a request and of a response.
   localparam int OPCODE_W = 3;
   localparam int POS_W = 7;
   localparam int DATA_W = 64;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // Default number of list entries.
   localparam int CAPACITY_DEFAULT = 64;

   // Request operation codes; the eighth code is unused and fails.
   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND            = 3'd0,
      OP_SET_LENGTH        = 3'd1,
      OP_REMOVE_AT         = 3'd2,
      OP_REMOVE_AT_SWAP    = 3'd3,
      OP_REMOVE_VALUE      = 3'd4,
      OP_REMOVE_VALUE_SWAP = 3'd5,
      OP_FIND              = 3'd6
   } opcode_type;

   // Datapath commands issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      CMD_NONE         = 4'd0,
      CMD_LOAD         = 4'd1,
      CMD_APPEND       = 4'd2,
      CMD_FILL_INIT    = 4'd3,
      CMD_FILL_STEP    = 4'd4,
      CMD_SET_LEN      = 4'd5,
      CMD_TAKE_POS     = 4'd6,
      CMD_SCAN_INIT    = 4'd7,
      CMD_SCAN_STEP    = 4'd8,
      CMD_SHIFT_INIT   = 4'd9,
      CMD_SHIFT_STEP   = 4'd10,
      CMD_SHIFT_END    = 4'd11,
      CMD_SWAP_RD_GAP  = 4'd12,
      CMD_SWAP_RD_LAST = 4'd13,
      CMD_SWAP_WR      = 4'd14
   } dp_cmd_type;

   // Controller to datapath.
   typedef struct packed {
      dp_cmd_type op;
      logic       out_load;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      opcode_type opcode;
      logic       fill_lt_cap;
      logic       pos_le_cap;
      logic       pos_lt_fill;
      logic       zero_more;
      logic       more;
      logic       pend;
      logic       hit;
   } ctl_stat_type;

endpackage

>>> src/ople_req_if.sv
// Request channel of the ordered list engine: valid, ready and the request fields.
// Depends on ople_pkg for the field widths.
interface ople_req_if;
   logic                              valid;
   logic                              ready;
   logic [ople_pkg::OPCODE_W-1:0]     opcode;
   logic [ople_pkg::POS_W-1:0]        position;
   logic [ople_pkg::DATA_W-1:0]       item_value;

   modport source (output valid, output opcode, output position, output item_value,
                   input ready);
   modport sink (input valid, input opcode, input position, input item_value,
                 output ready);
endinterface

>>> src/ople_rsp_if.sv
// Response channel of the ordered list engine: valid, ready and the response fields.
// Depends on ople_pkg for the field widths.
interface ople_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              status;
   logic [ople_pkg::DATA_W-1:0]       removed_value;
   logic [ople_pkg::INDEX_W-1:0]      found_index;
   logic [ople_pkg::COUNT_W-1:0]      count;

   modport source (output valid, output status, output removed_value,
                   output found_index, output count, input ready);
   modport sink (input valid, input status, input removed_value,
                 input found_index, input count, output ready);
endinterface

>>> src/ople_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module ople_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/ople_ctrl.sv
// Controller of the ordered list engine: sequences each request through the datapath.
// Depends on ople_pkg for the command and status structs.
module ople_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ople_pkg::ctl_cmd_type  cmd,
   input  ople_pkg::ctl_stat_type stat
);

   typedef enum logic [9:0] {
      ST_IDLE        = 10'b0000000001,
      ST_EXEC        = 10'b0000000010,
      ST_FILL        = 10'b0000000100,
      ST_SCAN        = 10'b0000001000,
      ST_SHIFT_START = 10'b0000010000,
      ST_SHIFT       = 10'b0000100000,
      ST_SWAP_A      = 10'b0001000000,
      ST_SWAP_B      = 10'b0010000000,
      ST_SWAP_C      = 10'b0100000000,
      ST_DONE        = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // A new request is taken whenever the engine is idle, even with a response waiting.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = ople_pkg::CMD_NONE;
      cmd.out_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ople_pkg::CMD_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (stat.opcode) inside
               ople_pkg::OP_APPEND: begin
                  if (stat.fill_lt_cap) begin
                     cmd.op = ople_pkg::CMD_APPEND;
                  end
               end
               ople_pkg::OP_SET_LENGTH: begin
                  if (stat.pos_le_cap) begin
                     cmd.op   = ople_pkg::CMD_FILL_INIT;
                     state_in = ST_FILL;
                  end
               end
               ople_pkg::OP_REMOVE_AT: begin
                  if (stat.pos_lt_fill) begin
                     cmd.op   = ople_pkg::CMD_TAKE_POS;
                     state_in = ST_SHIFT_START;
                  end
               end
               ople_pkg::OP_REMOVE_AT_SWAP: begin
                  if (stat.pos_lt_fill) begin
                     cmd.op   = ople_pkg::CMD_TAKE_POS;
                     state_in = ST_SWAP_A;
                  end
               end
               ople_pkg::OP_REMOVE_VALUE, ople_pkg::OP_REMOVE_VALUE_SWAP,
               ople_pkg::OP_FIND: begin
                  cmd.op   = ople_pkg::CMD_SCAN_INIT;
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FILL: begin
            // Zero one new entry a cycle, then take the new length.
            if (stat.zero_more) begin
               cmd.op = ople_pkg::CMD_FILL_STEP;
            end else begin
               cmd.op   = ople_pkg::CMD_SET_LEN;
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.op = ople_pkg::CMD_SCAN_STEP;
            if (stat.hit) begin
               if (stat.opcode == ople_pkg::OP_REMOVE_VALUE) begin
                  state_in = ST_SHIFT_START;
               end else if (stat.opcode == ople_pkg::OP_REMOVE_VALUE_SWAP) begin
                  state_in = ST_SWAP_A;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (!stat.more && !stat.pend) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_START: begin
            cmd.op   = ople_pkg::CMD_SHIFT_INIT;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (!stat.more && !stat.pend) begin
               cmd.op   = ople_pkg::CMD_SHIFT_END;
               state_in = ST_DONE;
            end else begin
               cmd.op = ople_pkg::CMD_SHIFT_STEP;
            end
         end
         ST_SWAP_A: begin
            cmd.op   = ople_pkg::CMD_SWAP_RD_GAP;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            cmd.op   = ople_pkg::CMD_SWAP_RD_LAST;
            state_in = ST_SWAP_C;
         end
         ST_SWAP_C: begin
            cmd.op   = ople_pkg::CMD_SWAP_WR;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and response-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/ople_dp.sv
// Datapath of the ordered list engine: entry memory, fill count, scan pointer, results.
// Depends on ople_pkg and instantiates ople_ram.
module ople_dp #(
   parameter int CAPACITY = ople_pkg::CAPACITY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ople_pkg::OPCODE_W-1:0]   opcode,
   input  logic [ople_pkg::POS_W-1:0]      position,
   input  logic [ople_pkg::DATA_W-1:0]     item_value,
   output logic                            status,
   output logic [ople_pkg::DATA_W-1:0]     removed_value,
   output logic [ople_pkg::INDEX_W-1:0]    found_index,
   output logic [ople_pkg::COUNT_W-1:0]    count,
   input  ople_pkg::ctl_cmd_type           cmd,
   output ople_pkg::ctl_stat_type          stat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > ople_pkg::POS_W) ? CW : ople_pkg::POS_W;
   localparam int IW = (AW > ople_pkg::INDEX_W) ? AW : ople_pkg::INDEX_W;

   ople_pkg::opcode_type            op_ff, op_in;
   logic [ople_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [ople_pkg::DATA_W-1:0]     val_ff, val_in;
   logic [CW-1:0]                   fill_ff, fill_in;
   logic [CW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   chk_addr_ff, chk_addr_in;
   logic                            chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                   hit_idx_ff, hit_idx_in;
   logic                            status_ff, status_in;
   logic [ople_pkg::DATA_W-1:0]     removed_ff, removed_in;
   logic [ople_pkg::INDEX_W-1:0]    found_ff, found_in;
   logic                            out_status_ff;
   logic [ople_pkg::DATA_W-1:0]     out_removed_ff;
   logic [ople_pkg::INDEX_W-1:0]    out_found_ff;
   logic [ople_pkg::COUNT_W-1:0]    out_count_ff;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [ople_pkg::DATA_W-1:0]     wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [ople_pkg::DATA_W-1:0]     rd_data;

   logic [PW-1:0]                   pos_ext;
   logic [PW-1:0]                   fill_ext;
   logic [IW-1:0]                   chk_ext;
   logic [CW-1:0]                   fill_m1;
   logic                            more;
   logic                            hit;

   ople_ram #(
      .WIDTH (ople_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Common compares, sent to the controller as status.
   assign pos_ext  = PW'(pos_ff);
   assign fill_ext = PW'(fill_ff);
   assign chk_ext  = IW'(chk_addr_ff);
   assign fill_m1  = fill_ff - CW'(1);
   assign more     = ptr_ff < fill_ff;
   assign hit      = chk_vld_ff && (rd_data == val_ff);

   assign stat.opcode      = op_ff;
   assign stat.fill_lt_cap = fill_ff < CW'(CAPACITY);
   assign stat.pos_le_cap  = pos_ext <= PW'(CAPACITY);
   assign stat.pos_lt_fill = pos_ext < fill_ext;
   assign stat.zero_more   = PW'(ptr_ff) < pos_ext;
   assign stat.more        = more;
   assign stat.pend        = chk_vld_ff;
   assign stat.hit         = hit;

   assign status        = out_status_ff;
   assign removed_value = out_removed_ff;
   assign found_index   = out_found_ff;
   assign count         = out_count_ff;

   // Command execution: register updates and memory accesses.
   always_comb begin
      op_in       = op_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      chk_addr_in = chk_addr_ff;
      chk_vld_in  = chk_vld_ff;
      hit_idx_in  = hit_idx_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      found_in    = found_ff;
      wr_en       = 1'b0;
      wr_addr     = fill_ff[AW-1:0];
      wr_data     = val_ff;
      rd_addr     = '0;
      case (cmd.op)
         ople_pkg::CMD_LOAD: begin
            op_in      = ople_pkg::opcode_type'(opcode);
            pos_in     = position;
            val_in     = item_value;
            status_in  = 1'b1;
            removed_in = '0;
            found_in   = '0;
         end
         ople_pkg::CMD_APPEND: begin
            wr_en     = 1'b1;
            fill_in   = fill_ff + CW'(1);
            status_in = 1'b0;
         end
         ople_pkg::CMD_FILL_INIT: begin
            ptr_in = fill_ff;
         end
         ople_pkg::CMD_FILL_STEP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = '0;
            ptr_in  = ptr_ff + CW'(1);
         end
         ople_pkg::CMD_SET_LEN: begin
            fill_in   = pos_ext[CW-1:0];
            status_in = 1'b0;
         end
         ople_pkg::CMD_TAKE_POS: begin
            hit_idx_in = pos_ext[AW-1:0];
         end
         ople_pkg::CMD_SCAN_INIT: begin
            ptr_in     = '0;
            chk_vld_in = 1'b0;
         end
         ople_pkg::CMD_SCAN_STEP: begin
            // Compare the entry read last cycle while the next read goes out.
            if (hit) begin
               found_in   = chk_ext[ople_pkg::INDEX_W-1:0];
               hit_idx_in = chk_addr_ff;
               status_in  = 1'b0;
               chk_vld_in = 1'b0;
            end else if (more) begin
               rd_addr     = ptr_ff[AW-1:0];
               chk_addr_in = ptr_ff[AW-1:0];
               chk_vld_in  = 1'b1;
               ptr_in      = ptr_ff + CW'(1);
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         ople_pkg::CMD_SHIFT_INIT: begin
            ptr_in     = CW'(hit_idx_ff);
            chk_vld_in = 1'b0;
         end
         ople_pkg::CMD_SHIFT_STEP: begin
            // The gap entry is the removed value; each later one moves down a slot.
            if (chk_vld_ff) begin
               if (chk_addr_ff == hit_idx_ff) begin
                  removed_in = rd_data;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = chk_addr_ff - AW'(1);
                  wr_data = rd_data;
               end
            end
            if (more) begin
               rd_addr     = ptr_ff[AW-1:0];
               chk_addr_in = ptr_ff[AW-1:0];
               chk_vld_in  = 1'b1;
               ptr_in      = ptr_ff + CW'(1);
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         ople_pkg::CMD_SHIFT_END: begin
            fill_in   = fill_m1;
            status_in = 1'b0;
         end
         ople_pkg::CMD_SWAP_RD_GAP: begin
            rd_addr = hit_idx_ff;
         end
         ople_pkg::CMD_SWAP_RD_LAST: begin
            removed_in = rd_data;
            rd_addr    = fill_m1[AW-1:0];
         end
         ople_pkg::CMD_SWAP_WR: begin
            wr_en     = 1'b1;
            wr_addr   = hit_idx_ff;
            wr_data   = rd_data;
            fill_in   = fill_m1;
            status_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      chk_addr_ff <= chk_addr_in;
      hit_idx_ff  <= hit_idx_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff  <= status_ff;
         out_removed_ff <= removed_ff;
         out_found_ff   <= found_ff;
         out_count_ff   <= fill_ext[ople_pkg::COUNT_W-1:0];
      end
   end

endmodule

>>> src/ordered_pointer_list_engine_unit.sv
// Ordered list engine: a fixed-capacity list of 64-bit entries with a fill count.
// Requests refused on their operands (a full list, a position out of range, the
// unused code) fail; set length zeroes each new entry in turn, remove at a position
// shifts every later entry down a slot, its swap form moves the last entry into the
// gap, and find and the remove-value forms scan from the front for a match. The entry
// memory does one write and one registered read per cycle, so shifts and searches
// walk one entry a cycle. One request is worked on at a time; a new request is taken
// as soon as the engine is idle, even while the last response waits.
// Depends on ople_pkg, the two channel interfaces, ople_ctrl and ople_dp.
module ordered_pointer_list_engine_unit #(
   parameter int CAPACITY = ople_pkg::CAPACITY_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   ople_req_if.sink   req_if,
   ople_rsp_if.source rsp_if
);

   ople_pkg::ctl_cmd_type  cmd;
   ople_pkg::ctl_stat_type stat;

   // Sequencing of each request.
   ople_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Entry storage and result registers.
   ople_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .opcode        (req_if.opcode),
      .position      (req_if.position),
      .item_value    (req_if.item_value),
      .status        (rsp_if.status),
      .removed_value (rsp_if.removed_value),
      .found_index   (rsp_if.found_index),
      .count         (rsp_if.count),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

>>> src/ople_checker.sv
// Port-level checks of the ordered list engine, bound to the top level.
// Depends on ople_pkg for the field widths.
module ople_checker #(
   parameter int CAPACITY = ople_pkg::CAPACITY_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic [ople_pkg::DATA_W-1:0]  rsp_removed_value,
   input logic [ople_pkg::INDEX_W-1:0] rsp_found_index,
   input logic [ople_pkg::COUNT_W-1:0] rsp_count
);

   localparam bit COUNT_FULL = CAPACITY > 127;

   // A stalled response holds its valid and its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_removed_value) && $stable(rsp_found_index) && $stable(rsp_count))
      else $error("response changed while stalled");

   // Out of reset the engine is idle with nothing to deliver.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("engine not idle after reset");

   // An accepted request keeps the engine busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one was in flight");

   // The reported count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> COUNT_FULL || (rsp_count <= CAPACITY))
      else $error("count beyond capacity");

   // A failed request reports no removed entry and no index.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_removed_value == '0) && (rsp_found_index == '0))
      else $error("failed request with nonzero result fields");

endmodule

bind ordered_pointer_list_engine_unit ople_checker #(
   .CAPACITY (CAPACITY)
) u_ople_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_removed_value (rsp_if.removed_value),
   .rsp_found_index   (rsp_if.found_index),
   .rsp_count         (rsp_if.count)
);
